[src/sst_pkg.sv]
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types, codes and the key compare for the small set table.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 64;
    localparam int POS_W    = 5;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_INT  = 2'd1;
    localparam logic [1:0] KIND_DBL  = 2'd2;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [63:0] SIGN_MASK = 64'h8000_0000_0000_0000;
    localparam logic [63:0] EXP_MASK  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] MANT_MASK = 64'h000F_FFFF_FFFF_FFFF;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } sst_state_t;

    typedef struct packed {
        logic capture;
        logic remove_go;
        logic load;
        logic valid;
    } sst_cell_ctrl_t;

    function automatic logic is_nan64(logic [63:0] x);
        return ((x & EXP_MASK) == EXP_MASK) && ((x & MANT_MASK) != 64'd0);
    endfunction

    function automatic logic keys_equal(logic [1:0] kind, logic [63:0] a, logic [63:0] b);
        logic eq;
        eq = 1'b0;
        case (kind)
            KIND_CHAR: eq = (a[7:0] == b[7:0]);
            KIND_INT:  eq = (a[31:0] == b[31:0]);
            default:
            begin
                if (is_nan64(a) || is_nan64(b))
                    eq = 1'b0;
                else if (((a | b) & ~SIGN_MASK) == 64'd0)
                    eq = 1'b1;
                else
                    eq = (a == b);
            end
        endcase
        return eq;
    endfunction

endpackage

[src/small_set_table.sv]
// Cells register the compare of an accepted word; ST_UPDATE then registers done.
// No new word while busy; compare in the accept cycle, update in the next.
// The result is shown for one cycle; the receiver cannot stall.
// Reset: fill_reg cleared, kind_reg set to int; stored keys are left as they are.
// ----------------------------------------------------------------------------
// small_set_table
// Packed set of keys in insertion order, built as a chain of compare cells.
// ----------------------------------------------------------------------------
module small_set_table
    import sst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         req_type,
    input  logic [KEY_W-1:0]   key,
    output logic               done,
    output logic [POS_W-1:0]   found_position,
    output logic [POS_W-1:0]   count,
    output logic               status
);

    sst_state_t        state_reg, state_next;
    logic [1:0]        kind_reg;
    logic [1:0]        req_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              done_reg;
    logic [POS_W-1:0]  pos_out_reg, pos_out_next;
    logic [POS_W-1:0]  cnt_out_reg;
    logic              status_reg, status_next;

    logic              accept;
    logic              updating;
    logic              found;
    logic              full;
    logic              add_go;
    logic              remove_go;
    logic [IDX_W-1:0]  pos_idx;
    logic [CAPACITY:0] seen;
    logic [CAPACITY-1:0] first;
    logic [KEY_W-1:0]  entries [CAPACITY];

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign updating  = (state_reg == ST_UPDATE);
    assign seen[0]   = 1'b0;
    assign found     = seen[CAPACITY];
    assign full      = (fill_reg == CNT_W'(CAPACITY));
    assign add_go    = updating && (req_reg == REQ_ADD) && !found && !full;
    assign remove_go = updating && (req_reg == REQ_REMOVE) && found;

    genvar j;
    generate
        for (j = 0; j < CAPACITY; j++)
        begin : g_cell
            sst_cell_ctrl_t   ctrl;
            logic [KEY_W-1:0] next_entry;

            assign ctrl.capture   = accept;
            assign ctrl.remove_go = remove_go;
            assign ctrl.load      = add_go && (fill_reg == CNT_W'(j));
            assign ctrl.valid     = (CNT_W'(j) < fill_reg);

            if (j == CAPACITY - 1)
            begin : g_last
                assign next_entry = entries[j];
            end
            else
            begin : g_mid
                assign next_entry = entries[j + 1];
            end

            sst_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .kind       (kind_reg),
                .key        (key),
                .load_key   (key_reg),
                .next_entry (next_entry),
                .seen_in    (seen[j]),
                .seen_out   (seen[j + 1]),
                .first      (first[j]),
                .entry      (entries[j])
            );
        end
    endgenerate

    always_comb
    begin
        pos_idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first[i])
                pos_idx = pos_idx | IDX_W'(i);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        status_next  = 1'b0;
        pos_out_next = found ? POS_W'({1'b0, pos_idx} + (IDX_W + 1)'(1)) : '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
                if (add_go)
                    fill_next = fill_reg + CNT_W'(1);
                else if (remove_go)
                    fill_next = fill_reg - CNT_W'(1);
                status_next = (req_reg == REQ_ADD) && !found && full;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= KIND_INT;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            done_reg  <= updating;
            if (cfg_we)
                kind_reg <= cfg_data;
        end
    end

    // hold the word for the update cycle; register the results during it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            key_reg <= key;
        end
        if (updating)
        begin
            pos_out_reg <= pos_out_next;
            cnt_out_reg <= POS_W'(fill_next);
            status_reg  <= status_next;
        end
    end

    assign done           = done_reg;
    assign found_position = pos_out_reg;
    assign count          = cnt_out_reg;
    assign status         = status_reg;

endmodule

[src/sst_cell.sv]
// ----------------------------------------------------------------------------
// sst_cell
// One slot of the set: holds a key, compares it, shifts from its neighbor.
// ----------------------------------------------------------------------------
module sst_cell
    import sst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  sst_cell_ctrl_t     ctrl,
    input  logic [1:0]         kind,
    input  logic [KEY_W-1:0]   key,
    input  logic [KEY_W-1:0]   load_key,
    input  logic [KEY_W-1:0]   next_entry,
    input  logic               seen_in,
    output logic               seen_out,
    output logic               first,
    output logic [KEY_W-1:0]   entry
);

    logic [KEY_W-1:0] entry_reg;
    logic             match_reg;

    assign seen_out = seen_in | match_reg;
    assign first    = match_reg & ~seen_in;
    assign entry    = entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= 1'b0;
        else if (ctrl.capture)
            match_reg <= ctrl.valid & keys_equal(kind, entry_reg, key);
    end

    // advance from the neighbor at and after the hit; append on load
    always_ff @(posedge clk)
    begin
        if (ctrl.remove_go && seen_out)
            entry_reg <= next_entry;
        else if (ctrl.load)
            entry_reg <= load_key;
    end

endmodule

[src/sst_checker.sv]
// ----------------------------------------------------------------------------
// sst_checker
// Port-level checks on the small set table handshake and results.
// ----------------------------------------------------------------------------
module sst_checker
    import sst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               done,
    input  logic [POS_W-1:0]   found_position,
    input  logic               status
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result missing two cycles after accept");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_refused_absent: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (found_position == '0))
        else $error("refused add reports a position");

endmodule

bind small_set_table sst_checker u_sst_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .found_position (found_position),
    .status         (status)
);
